// ----- hw/rtl/vvma_pkg.sv -----
`default_nettype none

package vvma_pkg;

    localparam int LEN_W            = 24;
    localparam int IDX_W            = 10;
    localparam int MASS_W           = 56;
    localparam int MUL_W            = 104;
    localparam int MY_W             = 50;
    localparam int ALU_W            = 106;
    localparam int DEF_NUM_VERTICES = 1024;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [LEN_W-1:0] len_a;
        logic [LEN_W-1:0] len_b;
        logic [LEN_W-1:0] len_c;
        logic [IDX_W-1:0] vert_a;
        logic [IDX_W-1:0] vert_b;
        logic [IDX_W-1:0] vert_c;
        logic [IDX_W-1:0] read_vertex;
    } vvma_in_t;

    typedef struct packed {
        logic [MASS_W-1:0] mass;
        logic [IDX_W-1:0]  mass_vertex;
    } vvma_out_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL,
        S_SQRT,
        S_TRI,
        S_NSUM,
        S_DIV,
        S_ACC_RD,
        S_ACC_WR
    } state_t;

    typedef enum logic [2:0] {
        PH_T1,
        PH_T2,
        PH_P,
        PH_SQ,
        PH_N,
        PH_PART
    } phase_t;

endpackage

`default_nettype wire

// ----- hw/rtl/voronoi_vertex_mass_accumulator.sv -----
// channel   | ports                  | handshake
// ----------+------------------------+------------------------------------------
// command   | start, busy, item      | taken when start is high and busy is low
// result    | done, result           | one cycle per read, receiver cannot stall
//
// an add takes longer than a read, and is shorter when one corner is obtuse; its work
// is done by one shared 106-bit adder driving a shift-add multiplier, a 52-step
// square root and 32-step fraction divisions.
// a degenerate add is dropped in the cycle it is taken.
// after reset the mass memory is cleared one entry a cycle, every entry in turn,
// and busy stays high during that pass.
`default_nettype none

module voronoi_vertex_mass_accumulator #(
    parameter int NUM_VERTICES = vvma_pkg::DEF_NUM_VERTICES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire vvma_pkg::vvma_in_t item,
    output logic                    done,
    output vvma_pkg::vvma_out_t     result
);

    localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int LW = vvma_pkg::LEN_W;
    localparam int XW = vvma_pkg::IDX_W;
    localparam int MW = vvma_pkg::MUL_W;
    localparam int YW = vvma_pkg::MY_W;
    localparam int UW = vvma_pkg::ALU_W;
    localparam int SW = vvma_pkg::MASS_W;

    vvma_pkg::state_t state_reg, state_next;
    vvma_pkg::phase_t phase_reg, phase_next;
    logic [1:0]    k_reg, k_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          done_reg, done_next;

    logic [LW-1:0] len_reg [3];
    logic [LW-1:0] len_next [3];
    logic [XW-1:0] vert_reg [3];
    logic [XW-1:0] vert_next [3];
    logic [47:0]   sq_reg [3];
    logic [47:0]   sq_next [3];
    logic [YW-1:0] t_reg [3];
    logic [YW-1:0] t_next [3];
    logic [97:0]   n_reg [3];
    logic [97:0]   n_next [3];
    logic [49:0]   part_reg [3];
    logic [49:0]   part_next [3];

    logic [24:0]   f2_reg, f2_next, f3_reg, f3_next;
    logic [25:0]   s_reg, s_next;
    logic [49:0]   t1_reg, t1_next;
    logic [MW-1:0] p_reg, p_next;
    logic [MW-1:0] sqp_reg, sqp_next;
    logic [53:0]   rem_reg, rem_next;
    logic [51:0]   root_reg, root_next;
    logic [49:0]   area_reg, area_next;
    logic [104:0]  dm_reg, dm_next;
    logic [31:0]   q_reg, q_next;
    logic [MW-1:0] mx_reg, mx_next;
    logic [YW-1:0] my_reg, my_next;
    logic [MW-1:0] acc_reg, acc_next;
    logic [XW-1:0] rv_reg, rv_next;
    logic          rin_reg, rin_next;
    logic [SW-1:0] mass_reg, mass_next;
    logic [XW-1:0] mv_reg, mv_next;

    logic [SW-1:0] mem [NUM_VERTICES];
    logic [SW-1:0] rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [SW-1:0] mem_wdata;

    logic [UW-1:0] alu_a, alu_b, alu_res;
    logic          alu_sub;

    logic [25:0]   f1_w, f2_w, f3_w;
    logic          degen;
    logic [53:0]   rem_sh, trial;
    logic          sq_ge;
    logic [104:0]  mm;
    logic          div_ge;
    logic [31:0]   q_w;
    logic [50:0]   ta_w, tb_w, tc_w;
    logic          obtuse;
    logic [56:0]   acc_sum;
    logic [SW-1:0] acc_sat;
    logic          vin_k;
    logic          rin_w;

    function automatic logic idx_ok(input logic [XW-1:0] v);
        return 21'(v) < 21'(NUM_VERTICES);
    endfunction

    function automatic logic [AW-1:0] idx_addr(input logic [XW-1:0] v);
        logic [20:0] e;
        e = 21'(v);
        return e[AW-1:0];
    endfunction

    assign f1_w  = {2'b00, item.len_a} + {2'b00, item.len_b} - {2'b00, item.len_c};
    assign f2_w  = {2'b00, item.len_a} - {2'b00, item.len_b} + {2'b00, item.len_c};
    assign f3_w  = {2'b00, item.len_b} + {2'b00, item.len_c} - {2'b00, item.len_a};
    assign degen = f1_w[25] || (f1_w == '0) || f2_w[25] || (f2_w == '0)
                   || f3_w[25] || (f3_w == '0);
    assign rin_w = idx_ok(item.read_vertex);

    assign rem_sh = {rem_reg[51:0], sqp_reg[MW-1:MW-2]};
    assign trial  = {root_reg, 2'b01};
    assign sq_ge  = !alu_res[UW-1];
    assign mm     = (cnt_reg == '0) ? dm_reg : {dm_reg[103:0], 1'b0};
    assign div_ge = !alu_res[UW-1];
    assign q_w    = {q_reg[30:0], div_ge};

    assign ta_w   = {3'b000, sq_reg[1]} + {3'b000, sq_reg[2]} - {3'b000, sq_reg[0]};
    assign tb_w   = {3'b000, sq_reg[0]} + {3'b000, sq_reg[2]} - {3'b000, sq_reg[1]};
    assign tc_w   = {3'b000, sq_reg[0]} + {3'b000, sq_reg[1]} - {3'b000, sq_reg[2]};
    assign obtuse = ta_w[50] || tb_w[50] || tc_w[50];

    assign vin_k   = idx_ok(vert_reg[k_reg]);
    assign acc_sum = {1'b0, rdata_reg} + 57'(part_reg[k_reg]);
    assign acc_sat = acc_sum[56] ? {SW{1'b1}} : acc_sum[SW-1:0];

    // shared adder
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            vvma_pkg::S_MUL:
            begin
                alu_a = UW'(acc_reg);
                alu_b = my_reg[0] ? UW'(mx_reg) : '0;
            end
            vvma_pkg::S_SQRT:
            begin
                alu_a   = UW'(rem_sh);
                alu_b   = UW'(trial);
                alu_sub = 1'b1;
            end
            vvma_pkg::S_DIV:
            begin
                alu_a   = UW'(mm);
                alu_b   = UW'(p_reg);
                alu_sub = 1'b1;
            end
            vvma_pkg::S_NSUM:
            begin
                case (k_reg)
                    2'd0:
                    begin
                        alu_a = UW'(n_reg[1]);
                        alu_b = UW'(n_reg[2]);
                    end
                    2'd1:
                    begin
                        alu_a = UW'(n_reg[0]);
                        alu_b = UW'(n_reg[2]);
                    end
                    default:
                    begin
                        alu_a = UW'(n_reg[0]);
                        alu_b = UW'(n_reg[1]);
                    end
                endcase
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vvma_pkg::S_CLEAR:
            begin
                if (clr_reg == AW'(NUM_VERTICES - 1))
                begin
                    state_next = vvma_pkg::S_IDLE;
                end
            end
            vvma_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (item.cmd == vvma_pkg::CMD_READ)
                    begin
                        state_next = vvma_pkg::S_READ;
                    end
                    else if (!degen)
                    begin
                        state_next = vvma_pkg::S_MUL;
                    end
                end
            end
            vvma_pkg::S_READ:
            begin
                state_next = vvma_pkg::S_IDLE;
            end
            vvma_pkg::S_MUL:
            begin
                if (my_reg == '0)
                begin
                    case (phase_reg)
                        vvma_pkg::PH_P:
                        begin
                            state_next = vvma_pkg::S_SQRT;
                        end
                        vvma_pkg::PH_SQ:
                        begin
                            if (k_reg == 2'd2)
                            begin
                                state_next = vvma_pkg::S_TRI;
                            end
                        end
                        vvma_pkg::PH_N:
                        begin
                            if (k_reg == 2'd2)
                            begin
                                state_next = vvma_pkg::S_NSUM;
                            end
                        end
                        vvma_pkg::PH_PART:
                        begin
                            state_next = (k_reg == 2'd2) ? vvma_pkg::S_ACC_RD
                                                         : vvma_pkg::S_NSUM;
                        end
                        default:
                        begin
                            state_next = vvma_pkg::S_MUL;
                        end
                    endcase
                end
            end
            vvma_pkg::S_SQRT:
            begin
                if (cnt_reg == 6'd51)
                begin
                    state_next = vvma_pkg::S_MUL;
                end
            end
            vvma_pkg::S_TRI:
            begin
                state_next = obtuse ? vvma_pkg::S_ACC_RD : vvma_pkg::S_MUL;
            end
            vvma_pkg::S_NSUM:
            begin
                state_next = vvma_pkg::S_DIV;
            end
            vvma_pkg::S_DIV:
            begin
                if (cnt_reg == 6'd31)
                begin
                    state_next = vvma_pkg::S_MUL;
                end
            end
            vvma_pkg::S_ACC_RD:
            begin
                if (vin_k)
                begin
                    state_next = vvma_pkg::S_ACC_WR;
                end
                else if (k_reg == 2'd2)
                begin
                    state_next = vvma_pkg::S_IDLE;
                end
            end
            vvma_pkg::S_ACC_WR:
            begin
                state_next = (k_reg == 2'd2) ? vvma_pkg::S_IDLE : vvma_pkg::S_ACC_RD;
            end
            default:
            begin
                state_next = vvma_pkg::S_IDLE;
            end
        endcase
    end

    // memory control and result
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = clr_reg;
        mem_raddr = idx_addr(vert_reg[k_reg]);
        mem_wdata = '0;
        done_next = 1'b0;
        mass_next = mass_reg;
        mv_next   = mv_reg;
        clr_next  = clr_reg;
        case (state_reg)
            vvma_pkg::S_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
            end
            vvma_pkg::S_IDLE:
            begin
                mem_raddr = idx_addr(item.read_vertex);
                mem_re    = start && (item.cmd == vvma_pkg::CMD_READ) && rin_w;
            end
            vvma_pkg::S_READ:
            begin
                done_next = 1'b1;
                mass_next = rin_reg ? rdata_reg : '0;
                mv_next   = rv_reg;
            end
            vvma_pkg::S_ACC_RD:
            begin
                mem_re = vin_k;
            end
            vvma_pkg::S_ACC_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_addr(vert_reg[k_reg]);
                mem_wdata = acc_sat;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        phase_next = phase_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        vert_next  = vert_reg;
        sq_next    = sq_reg;
        t_next     = t_reg;
        n_next     = n_reg;
        part_next  = part_reg;
        f2_next    = f2_reg;
        f3_next    = f3_reg;
        s_next     = s_reg;
        t1_next    = t1_reg;
        p_next     = p_reg;
        sqp_next   = sqp_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        area_next  = area_reg;
        dm_next    = dm_reg;
        q_next     = q_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        acc_next   = acc_reg;
        rv_next    = rv_reg;
        rin_next   = rin_reg;
        case (state_reg)
            vvma_pkg::S_IDLE:
            begin
                rv_next  = item.read_vertex;
                rin_next = rin_w;
                len_next[0]  = item.len_a;
                len_next[1]  = item.len_b;
                len_next[2]  = item.len_c;
                vert_next[0] = item.vert_a;
                vert_next[1] = item.vert_b;
                vert_next[2] = item.vert_c;
                f2_next    = f2_w[24:0];
                f3_next    = f3_w[24:0];
                s_next     = {2'b00, item.len_a} + {2'b00, item.len_b}
                             + {2'b00, item.len_c};
                mx_next    = MW'(f1_w[24:0]);
                my_next    = YW'(f2_w[24:0]);
                acc_next   = '0;
                phase_next = vvma_pkg::PH_T1;
                k_next     = 2'd0;
            end
            vvma_pkg::S_MUL:
            begin
                if (my_reg == '0)
                begin
                    case (phase_reg)
                        vvma_pkg::PH_T1:
                        begin
                            t1_next    = acc_reg[49:0];
                            mx_next    = MW'(s_reg);
                            my_next    = YW'(f3_reg);
                            acc_next   = '0;
                            phase_next = vvma_pkg::PH_T2;
                        end
                        vvma_pkg::PH_T2:
                        begin
                            mx_next    = acc_reg;
                            my_next    = t1_reg;
                            acc_next   = '0;
                            phase_next = vvma_pkg::PH_P;
                        end
                        vvma_pkg::PH_P:
                        begin
                            p_next    = acc_reg;
                            sqp_next  = acc_reg;
                            rem_next  = '0;
                            root_next = '0;
                            cnt_next  = '0;
                        end
                        vvma_pkg::PH_SQ:
                        begin
                            sq_next[k_reg] = acc_reg[47:0];
                            if (k_reg != 2'd2)
                            begin
                                k_next   = k_reg + 2'd1;
                                mx_next  = MW'(len_reg[k_reg + 2'd1]);
                                my_next  = YW'(len_reg[k_reg + 2'd1]);
                                acc_next = '0;
                            end
                            else
                            begin
                                k_next = 2'd0;
                            end
                        end
                        vvma_pkg::PH_N:
                        begin
                            n_next[k_reg] = acc_reg[97:0];
                            if (k_reg != 2'd2)
                            begin
                                k_next   = k_reg + 2'd1;
                                mx_next  = MW'(sq_reg[k_reg + 2'd1]);
                                my_next  = t_reg[k_reg + 2'd1];
                                acc_next = '0;
                            end
                            else
                            begin
                                k_next = 2'd0;
                            end
                        end
                        default:
                        begin
                            part_next[k_reg] = acc_reg[81:32];
                            k_next = (k_reg != 2'd2) ? k_reg + 2'd1 : 2'd0;
                        end
                    endcase
                end
                else
                begin
                    acc_next = alu_res[MW-1:0];
                    mx_next  = {mx_reg[MW-2:0], 1'b0};
                    my_next  = {1'b0, my_reg[YW-1:1]};
                end
            end
            vvma_pkg::S_SQRT:
            begin
                rem_next  = sq_ge ? alu_res[53:0] : rem_sh;
                root_next = {root_reg[50:0], sq_ge};
                sqp_next  = {sqp_reg[MW-3:0], 2'b00};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd51)
                begin
                    area_next  = root_next[51:2];
                    mx_next    = MW'(len_reg[0]);
                    my_next    = YW'(len_reg[0]);
                    acc_next   = '0;
                    phase_next = vvma_pkg::PH_SQ;
                    k_next     = 2'd0;
                end
            end
            vvma_pkg::S_TRI:
            begin
                t_next[0] = ta_w[49:0];
                t_next[1] = tb_w[49:0];
                t_next[2] = tc_w[49:0];
                k_next    = 2'd0;
                if (ta_w[50])
                begin
                    part_next[0] = {1'b0, area_reg[49:1]};
                    part_next[1] = {2'b00, area_reg[49:2]};
                    part_next[2] = {2'b00, area_reg[49:2]};
                end
                else if (tb_w[50])
                begin
                    part_next[0] = {2'b00, area_reg[49:2]};
                    part_next[1] = {1'b0, area_reg[49:1]};
                    part_next[2] = {2'b00, area_reg[49:2]};
                end
                else if (tc_w[50])
                begin
                    part_next[0] = {2'b00, area_reg[49:2]};
                    part_next[1] = {2'b00, area_reg[49:2]};
                    part_next[2] = {1'b0, area_reg[49:1]};
                end
                else
                begin
                    mx_next    = MW'(sq_reg[0]);
                    my_next    = ta_w[49:0];
                    acc_next   = '0;
                    phase_next = vvma_pkg::PH_N;
                end
            end
            vvma_pkg::S_NSUM:
            begin
                dm_next  = alu_res[104:0];
                cnt_next = '0;
                q_next   = '0;
            end
            vvma_pkg::S_DIV:
            begin
                dm_next  = div_ge ? alu_res[104:0] : mm;
                q_next   = q_w;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    mx_next    = MW'(area_reg);
                    my_next    = YW'(q_w);
                    acc_next   = '0;
                    phase_next = vvma_pkg::PH_PART;
                end
            end
            vvma_pkg::S_ACC_RD:
            begin
                if (!vin_k)
                begin
                    k_next = (k_reg != 2'd2) ? k_reg + 2'd1 : 2'd0;
                end
            end
            vvma_pkg::S_ACC_WR:
            begin
                k_next = (k_reg != 2'd2) ? k_reg + 2'd1 : 2'd0;
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vvma_pkg::S_CLEAR;
            phase_reg <= vvma_pkg::PH_T1;
            k_reg     <= '0;
            cnt_reg   <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        vert_reg <= vert_next;
        sq_reg   <= sq_next;
        t_reg    <= t_next;
        n_reg    <= n_next;
        part_reg <= part_next;
        f2_reg   <= f2_next;
        f3_reg   <= f3_next;
        s_reg    <= s_next;
        t1_reg   <= t1_next;
        p_reg    <= p_next;
        sqp_reg  <= sqp_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        area_reg <= area_next;
        dm_reg   <= dm_next;
        q_reg    <= q_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        acc_reg  <= acc_next;
        rv_reg   <= rv_next;
        rin_reg  <= rin_next;
        mass_reg <= mass_next;
        mv_reg   <= mv_next;
    end

    // mass memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign busy               = (state_reg != vvma_pkg::S_IDLE);
    assign done               = done_reg;
    assign result.mass        = mass_reg;
    assign result.mass_vertex = mv_reg;

endmodule

`default_nettype wire
